[sv/tcw_pkg.sv]
// Package for the text console cursor writer: geometry constants, character
// codes, function codes and the command and status bundles.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int SCROLL_CNT = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int TAB_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int IN_ADDR_W = 11;
  localparam int CELL_W    = 16;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  localparam logic [CHAR_W-1:0]  CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    FILL_RESET,
    FILL_CLEAR,
    FILL_TEXT
  } fill_sel_t;

  typedef struct packed {
    logic      load;
    logic      cnt_clr;
    logic      fill;
    fill_sel_t fill_sel;
    logic      copy_rd;
    logic      put;
    logic      nl;
    logic      rd_cell;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_nul;
    logic              is_nl;
    logic              fill_last;
    logic              copy_last;
    logic              col_at_end;
    logic              tab_more;
    logic              row_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/tcw_datapath.sv]
// Datapath of the text console cursor writer: screen store, cursor, sweep
// counter, item and result registers.
// Depends on tcw_pkg.
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic [COLOR_W-1:0]   in_clear_color,
  input  wire logic [IN_ADDR_W-1:0] in_cell_address,
  input  wire logic                 cfg_we,
  input  wire logic [COLOR_W-1:0]   cfg_wdata,
  output logic [CELL_W-1:0]         out_cell_data,
  output logic [OUT_ROW_W-1:0]      out_cursor_row,
  output logic [OUT_COL_W-1:0]      out_cursor_col
);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [FUNC_W-1:0]    func_r;
  logic [CHAR_W-1:0]    char_r;
  logic [COLOR_W-1:0]   ccolor_r;
  logic [IN_ADDR_W-1:0] addr_r;
  logic [COLOR_W-1:0]   text_color_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [TAB_W-1:0]     tab_r, tab_nxt;
  logic [ADDR_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    cnt_d_r;
  logic                 cp_vld_r;
  logic [CELL_W-1:0]    rdata_r;
  logic [CELL_W-1:0]    out_cell_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;

  logic                 is_tab;
  logic                 addr_ok;
  logic                 tab_stop;
  logic [ADDR_W-1:0]    cur_idx;
  logic [COLOR_W-1:0]   fill_color;
  logic [CHAR_W-1:0]    put_char;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;

  assign is_tab   = (char_r == CH_TAB);
  assign addr_ok  = (32'(addr_r) < CELL_COUNT);
  assign tab_stop = (tab_r == TAB_W'(TAB_WIDTH - 1));
  assign cur_idx  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign put_char = is_tab ? CH_BLANK : char_r;

  assign sts.func       = func_r;
  assign sts.is_nul     = (char_r == CH_NUL);
  assign sts.is_nl      = (char_r == CH_NEWLINE);
  assign sts.fill_last  = (cnt_r == ADDR_W'(CELL_COUNT - 1));
  assign sts.copy_last  = (cnt_r == ADDR_W'(SCROLL_CNT - 1));
  assign sts.col_at_end = (col_r == COL_W'(COLUMNS - 1));
  assign sts.tab_more   = is_tab && !tab_stop;
  assign sts.row_last   = (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    case (cmd.fill_sel)
      FILL_RESET: fill_color = RESET_COLOR;
      FILL_CLEAR: fill_color = ccolor_r;
      FILL_TEXT:  fill_color = text_color_r;
      default:    fill_color = RESET_COLOR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = {fill_color, CH_BLANK};
    if (cp_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_d_r;
      mem_wdata = rdata_r;
    end else if (cmd.fill) begin
      mem_we    = 1'b1;
    end else if (cmd.put) begin
      mem_we    = 1'b1;
      mem_waddr = cur_idx;
      mem_wdata = {text_color_r, put_char};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.fill || cmd.copy_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    tab_nxt = tab_r;
    if (cmd.put) begin
      col_nxt = sts.col_at_end ? '0 : col_r + 1'b1;
      tab_nxt = (sts.col_at_end || tab_stop) ? '0 : tab_r + 1'b1;
    end else if (cmd.nl) begin
      col_nxt = '0;
      tab_nxt = '0;
      row_nxt = sts.row_last ? row_r : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      tab_r        <= '0;
      cnt_r        <= '0;
      cp_vld_r     <= 1'b0;
      text_color_r <= RESET_COLOR;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      tab_r    <= tab_nxt;
      cnt_r    <= cnt_nxt;
      cp_vld_r <= cmd.copy_rd;
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_d_r <= cnt_r;
    if (cmd.load) begin
      func_r   <= in_func;
      char_r   <= in_char_code;
      ccolor_r <= in_clear_color;
      addr_r   <= in_cell_address;
    end
    if (cmd.out_load) begin
      out_cell_r <= (func_r == FUNC_READ && addr_ok) ? rdata_r : '0;
      out_row_r  <= OUT_ROW_W'(row_r);
      out_col_r  <= OUT_COL_W'(col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      rdata_r <= mem[cnt_r + ADDR_W'(COLUMNS)];
    end else if (cmd.rd_cell && addr_ok) begin
      rdata_r <= mem[ADDR_W'(addr_r)];
    end
  end

  assign out_cell_data  = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

endmodule

`default_nettype wire

[sv/tcw_ctrl.sv]
// Controller of the text console cursor writer: sequences reset clearing,
// character writes, scrolls, clears, reads and the result handshake.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_NL,
    S_COPY,
    S_COPY_END,
    S_BLANK,
    S_CLEAR,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.fill_sel = FILL_RESET;
    case (state_r)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_PUT: begin
            if (sts.is_nul) begin
              state_nxt = S_DONE;
            end else if (sts.is_nl) begin
              state_nxt = S_NL;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          FUNC_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_CLEAR;
          end
          FUNC_READ: state_nxt = S_READ;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_WRITE: begin
        cmd.put = 1'b1;
        if (sts.col_at_end) begin
          state_nxt = S_NL;
        end else if (!sts.tab_more) begin
          state_nxt = S_DONE;
        end
      end
      S_NL: begin
        cmd.nl      = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.row_last ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.copy_last) begin
          state_nxt = S_COPY_END;
        end
      end
      S_COPY_END: state_nxt = S_BLANK;
      S_BLANK: begin
        cmd.fill     = 1'b1;
        cmd.fill_sel = FILL_TEXT;
        if (sts.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.fill     = 1'b1;
        cmd.fill_sel = FILL_CLEAR;
        if (sts.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/text_console_cursor_writer.sv]
// Top level of the text console cursor writer.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage: an item on the in_ channel is a put-character, clear-screen or
// read-cell request; every item gives exactly one result beat on the out_
// channel carrying the read cell (zero unless reading) and the cursor.
// The text color register is written through cfg_we and cfg_wdata; the user
// must do so only while the block is idle, as the block does not enforce it.
// A character written in the last column wraps the cursor to the next row,
// a tab writes blanks up to the next tab stop, a clear fills every cell, and
// a row advance past the last row scrolls the store. The screen store moves
// one cell per cycle. One item is processed at a time. After reset the block
// runs a clearing pass that fills the store with blanks in color 7; in_ready
// stays low meanwhile.
// The result sits in an output register; a stalled receiver does not stop
// the next item from being accepted, but that item's result waits until
// the previous beat has been taken.
`default_nettype none

module text_console_cursor_writer
  import tcw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic [COLOR_W-1:0]   in_clear_color,
  input  wire logic [IN_ADDR_W-1:0] in_cell_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CELL_W-1:0]         out_cell_data,
  output logic [OUT_ROW_W-1:0]      out_cursor_row,
  output logic [OUT_COL_W-1:0]      out_cursor_col,
  input  wire logic                 cfg_we,
  input  wire logic [COLOR_W-1:0]   cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tcw_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .in_clear_color  (in_clear_color),
    .in_cell_address (in_cell_address),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_cell_data   (out_cell_data),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col)
  );

endmodule

`default_nettype wire

[verif/text_console_cursor_writer_test.sv]
// Self-checking testbench for text_console_cursor_writer: random put, clear and read beats
// are checked against a cycle-free model of the screen store, cursor and text color.
// Depends on tcw_pkg and the text_console_cursor_writer RTL.
module text_console_cursor_writer_test;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET = 290;
  localparam int CYCLE_LIMIT = 6000000;

  typedef enum logic [1:0] {
    CMD_ITEM,
    CMD_COLOR,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [FUNC_W-1:0]      func;
    logic [CHAR_W-1:0]      char_code;
    logic [COLOR_W-1:0]     clear_color;
    logic [IN_ADDR_W-1:0]   cell_address;
    logic [COLOR_W-1:0]     color;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } console_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [COLOR_W-1:0] in_clear_color = '0;
  logic [IN_ADDR_W-1:0] in_cell_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CELL_W-1:0] out_cell_data;
  logic [OUT_ROW_W-1:0] out_cursor_row;
  logic [OUT_COL_W-1:0] out_cursor_col;
  logic cfg_we = 1'b0;
  logic [COLOR_W-1:0] cfg_wdata = '0;

  console_cmd_t command_q[$];
  console_view_t console_view_q[$];

  logic [CELL_W-1:0] screen_copy[CELL_COUNT];
  int row_pos;
  int col_pos;
  logic [COLOR_W-1:0] text_color_q;

  logic in_took = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  logic [31:0] stall_tick = '0;
  int cycle_count = 0;
  int fail_count = 0;
  int n_items = 0;

  text_console_cursor_writer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .in_clear_color  (in_clear_color),
    .in_cell_address (in_cell_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_data   (out_cell_data),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void line_feed();
    col_pos = 0;
    row_pos = row_pos + 1;
    if (row_pos >= ROWS) begin
      for (int i = 0; i < SCROLL_CNT; i++) screen_copy[i] = screen_copy[i + COLUMNS];
      for (int i = SCROLL_CNT; i < CELL_COUNT; i++) screen_copy[i] = {text_color_q, CH_BLANK};
      row_pos = ROWS - 1;
    end
  endfunction

  function automatic void store_glyph(logic [CHAR_W-1:0] ch);
    int idx;
    idx = row_pos * COLUMNS + col_pos;
    if (idx < CELL_COUNT) screen_copy[idx] = {text_color_q, ch};
    col_pos = col_pos + 1;
  endfunction

  function automatic console_view_t console_apply(logic [FUNC_W-1:0] func,
      logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] ccol, logic [IN_ADDR_W-1:0] addr);
    console_view_t v;
    v.cell_data = '0;
    if (func == FUNC_PUT) begin
      if (ch == CH_NEWLINE) begin
        line_feed();
      end else if (ch != CH_NUL) begin
        if (ch == CH_TAB) begin
          do begin
            store_glyph(CH_BLANK);
          end while ((col_pos % TAB_WIDTH) != 0 && col_pos < COLUMNS);
        end else begin
          store_glyph(ch);
        end
        if (col_pos >= COLUMNS) line_feed();
      end
    end else if (func == FUNC_CLEAR) begin
      for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {ccol, CH_BLANK};
    end else if (func == FUNC_READ) begin
      if (addr < CELL_COUNT) v.cell_data = screen_copy[addr];
    end
    v.row = OUT_ROW_W'(row_pos);
    v.col = OUT_COL_W'(col_pos);
    return v;
  endfunction

  task automatic push_cmd(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
      logic [COLOR_W-1:0] ccol, logic [IN_ADDR_W-1:0] addr);
    console_cmd_t c;
    c.kind = CMD_ITEM;
    c.func = func;
    c.char_code = ch;
    c.clear_color = ccol;
    c.cell_address = addr;
    c.color = '0;
    command_q.push_back(c);
    if (func != FUNC_SPARE && !(func == FUNC_PUT && ch == CH_NUL)) n_items++;
  endtask

  task automatic push_put(logic [CHAR_W-1:0] ch);
    push_cmd(FUNC_PUT, ch, COLOR_W'($urandom_range(0, 255)),
             IN_ADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic push_clear(logic [COLOR_W-1:0] ccol);
    push_cmd(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)), ccol,
             IN_ADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic push_read(logic [IN_ADDR_W-1:0] addr);
    push_cmd(FUNC_READ, CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
             addr);
  endtask

  task automatic push_control(cmd_kind_t kind, logic [COLOR_W-1:0] value);
    console_cmd_t c;
    c = '0;
    c.kind = kind;
    c.color = value;
    command_q.push_back(c);
  endtask

  function automatic logic [IN_ADDR_W-1:0] pick_address();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return IN_ADDR_W'($urandom_range(0, 3 * COLUMNS - 1));
    if (roll < 70) return IN_ADDR_W'($urandom_range(CELL_COUNT - 3 * COLUMNS, CELL_COUNT - 1));
    if (roll < 90) return IN_ADDR_W'($urandom_range(0, CELL_COUNT - 1));
    return IN_ADDR_W'($urandom_range(CELL_COUNT, 2047));
  endfunction

  always @(negedge clk) begin : sender
    console_cmd_t cmd;
    logic valid_next;
    logic we_next;
    valid_next = in_valid && !in_took;
    we_next = 1'b0;
    if (rst_n && !valid_next) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (command_q.size() != 0) begin
        cmd = command_q[0];
        if (cmd.kind == CMD_ITEM) begin
          cmd = command_q.pop_front();
          in_func <= cmd.func;
          in_char_code <= cmd.char_code;
          in_clear_color <= cmd.clear_color;
          in_cell_address <= cmd.cell_address;
          valid_next = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end else if (console_view_q.size() == 0) begin
          cmd = command_q.pop_front();
          if (cmd.kind == CMD_COLOR) begin
            cfg_wdata <= cmd.color;
            we_next = 1'b1;
          end
        end
      end
    end
    in_valid <= valid_next;
    cfg_we <= we_next;
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    out_ready <= (stall_tick[9:8] == 2'b00) ||
                 !((stall_tick % 11) < 4 || (stall_tick % 17) == 6 ||
                   (stall_tick % 1009) < 30);
  end

  always @(posedge clk) begin : watcher
    console_view_t want;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (console_view_q.size() == 0) begin
          $error("Result beat arrived with no expectation pending.");
          fail_count++;
        end else begin
          want = console_view_q.pop_front();
          if (out_cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, actual %h", want.cell_data, out_cell_data);
            fail_count++;
          end
          if (out_cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, actual %0d", want.row, out_cursor_row);
            fail_count++;
          end
          if (out_cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, actual %0d", want.col, out_cursor_col);
            fail_count++;
          end
        end
      end
      if (cfg_we) text_color_q = cfg_wdata;
      if (in_valid && in_ready) begin
        console_view_q.push_back(console_apply(in_func, in_char_code, in_clear_color,
                                               in_cell_address));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int roll;
    int len;
    int lines_done;
    int next_color_at;
    logic drained;
    for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {RESET_COLOR, CH_BLANK};
    row_pos = 0;
    col_pos = 0;
    text_color_q = RESET_COLOR;

    push_read(11'd0);
    push_read(IN_ADDR_W'(CELL_COUNT - 1));
    push_read(11'd2047);
    push_put(8'h41);
    push_put(8'hFF);
    push_put(CH_NUL);
    push_put(CH_TAB);
    push_put(CH_TAB);
    push_put(CH_NEWLINE);
    push_cmd(FUNC_SPARE, 8'hFF, 8'hFF, 11'h7FF);
    push_read(11'd0);
    push_read(11'd1);
    push_read(11'd2);
    push_control(CMD_COLOR, 8'hFF);
    push_put(8'h01);
    push_read(IN_ADDR_W'(COLUMNS));
    push_clear(8'h00);
    push_read(11'd0);
    push_read(IN_ADDR_W'(CELL_COUNT - 1));
    push_control(CMD_COLOR, 8'h00);
    push_put(8'h80);
    push_put(CH_TAB);
    push_read(IN_ADDR_W'(COLUMNS + 1));
    push_clear(8'hFF);
    push_read(11'd1000);
    push_control(CMD_DRAIN, '0);

    lines_done = 1;
    next_color_at = n_items + 45;
    drained = 1'b0;
    while (n_items < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_clear(COLOR_W'($urandom_range(0, 255)));
      end else if (roll < 14) begin
        repeat ($urandom_range(2, 5)) push_read(pick_address());
      end else if (roll < 22) begin
        repeat ($urandom_range(18, 21)) push_put(CH_TAB);
        lines_done++;
      end else if (roll < 25 && lines_done >= ROWS && n_items < ITEM_TARGET - 100) begin
        repeat ($urandom_range(76, 84)) push_put(CHAR_W'($urandom_range(11, 255)));
        if (roll[0]) push_put(CH_TAB);
        lines_done++;
      end else if (roll < 28) begin
        if (roll[0]) push_put(CH_NUL);
        else push_cmd(FUNC_SPARE, CHAR_W'($urandom_range(0, 255)),
                      COLOR_W'($urandom_range(0, 255)), IN_ADDR_W'($urandom_range(0, 2047)));
      end else begin
        len = (lines_done < ROWS && roll < 45) ? 0 : $urandom_range(0, 8);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 15) push_put(CH_TAB);
          else if (roll < 25) push_read(pick_address());
          else push_put(CHAR_W'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 99) < 85) begin
          push_put(CH_NEWLINE);
          lines_done++;
        end
      end
      if (n_items >= next_color_at) begin
        push_control(CMD_COLOR, COLOR_W'($urandom_range(0, 255)));
        next_color_at = n_items + 45;
      end
      if (!drained && n_items >= ITEM_TARGET / 2) begin
        push_control(CMD_DRAIN, '0);
        drained = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (command_q.size() != 0 || in_valid) @(posedge clk);
    while (console_view_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
